/* rtl/frame_aged_handle_allocator_assert.svh */
// assertion macros for the handle allocator top level
`ifndef FRAME_AGED_HANDLE_ALLOCATOR_ASSERT_SVH
`define FRAME_AGED_HANDLE_ALLOCATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never be seen
`define FHA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/fha_pkg.sv */
// types and constants of the handle allocator
`timescale 1ns / 1ps
`default_nettype none

package fha_pkg;

	localparam int ID_W     = 32;
	localparam int HANDLE_W = 8;
	localparam int CNT_W    = 9;
	localparam int MAX_POOL = 256;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_BEGIN  = 2'd1,
		KIND_END    = 2'd2,
		KIND_RESET  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_ALLOC = 2'd1,
		ST_FULL  = 2'd2,
		ST_DONE  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LK_SCAN,
		S_LK_POP,
		S_LK_ALLOC,
		S_EF_OUTER,
		S_EF_LOAD,
		S_EF_INNER,
		S_EF_PUSH,
		S_EF_FIN
	} state_t;

	typedef struct packed {
		logic                init;
		logic [CNT_W-1:0]    init_n;
		logic                rd_en;
		logic                pop;
		logic                wr_en;
		logic [HANDLE_W-1:0] wr_pos;
		logic [HANDLE_W-1:0] wr_data;
		logic                add_en;
		logic [CNT_W-1:0]    add_val;
	} stk_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0]    count;
		logic [HANDLE_W-1:0] top;
	} stk_stat_t;

endpackage

`default_nettype wire

/* rtl/fha_cmp.sv */
// shared id comparator for lookup match and end-frame ranking
`timescale 1ns / 1ps
`default_nettype none

module fha_cmp import fha_pkg::*; (
	input  logic [ID_W-1:0] a,
	input  logic [ID_W-1:0] b,
	output logic            eq,
	output logic            lt
);

	assign eq = (a == b);
	assign lt = (a < b);

endmodule

`default_nettype wire

/* rtl/fha_stack.sv */
// free handle stack with implicit refill after a pool reset
`timescale 1ns / 1ps
`default_nettype none

module fha_stack import fha_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  stk_ctrl_t ctrl,
	output stk_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [HANDLE_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    fresh_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    top_pos;
	logic [HANDLE_W-1:0] rd_data_s1;
	logic [HANDLE_W-1:0] imp_val_s1;
	logic                imp_s1;

	// positions below fresh_q were never written since the last refill:
	// they hold n-1-pos
	assign top_pos = count_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(DEPTH);
			fresh_q <= CNT_W'(DEPTH);
			n_q     <= CNT_W'(DEPTH);
		end else if (ctrl.init) begin
			count_q <= ctrl.init_n;
			fresh_q <= ctrl.init_n;
			n_q     <= ctrl.init_n;
		end else if (ctrl.pop) begin
			count_q <= top_pos;
			if (top_pos < fresh_q) begin
				fresh_q <= top_pos;
			end
		end else if (ctrl.add_en) begin
			count_q <= count_q + ctrl.add_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_pos[AW-1:0]] <= ctrl.wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_s1 <= mem[top_pos[AW-1:0]];
			imp_s1     <= (top_pos < fresh_q);
			imp_val_s1 <= HANDLE_W'(n_q - count_q);
		end
	end

	assign stat.count = count_q;
	assign stat.top   = imp_s1 ? imp_val_s1 : rd_data_s1;

endmodule

`default_nettype wire

/* rtl/frame_aged_handle_allocator.sv */
// top level of the frame-aged handle allocator: sequencer, id table, used/valid bits
`timescale 1ns / 1ps
`default_nettype none

// Translates 32-bit ids into small handles. A command is taken at a clock edge
// with start high and busy low; kind selects lookup, begin frame, end frame or
// pool reset, id is read only by a lookup. Every command gives exactly one
// result word: done is high for one cycle with status and handle, in the cycle
// in which busy has dropped again, so the next command may start there.
// The receiver cannot stall; results are never held back.
// Command steps, with D = min(MAX_HANDLES, 256) table slots:
//   begin frame, pool reset: the result is given straight from idle
//   lookup: scans the D slots until a hit, else pops a free handle
//     when one is free; one id table read and one compare each cycle
//     through the shared comparator
//   end frame: walks the D slots, and every freed
//     entry is ranked against all slots through the same comparator
// One command is in flight at a time. cfg_we/cfg_wdata set the pool size that
// the next pool reset loads. After arst_n the table is empty and the free
// stack holds handles 0 to D-1 with handle 0 on top; no clearing pass runs.
module frame_aged_handle_allocator import fha_pkg::*; #(
	parameter int MAX_HANDLES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [ID_W-1:0]     id,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	output logic                done,
	output logic [1:0]          status,
	output logic [HANDLE_W-1:0] handle
);

	`include "frame_aged_handle_allocator_assert.svh"

	localparam int DEPTH = (MAX_HANDLES < MAX_POOL) ? MAX_HANDLES : MAX_POOL;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = AW + 1;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    hiu_q;
	logic [ID_W-1:0]     id_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       oi_q;
	logic [CNT_W-1:0]    rank_q;
	logic [CNT_W-1:0]    freed_q;
	logic [DEPTH-1:0]    valid_q;
	logic [DEPTH-1:0]    used_q;
	logic [DEPTH-1:0]    cand;
	logic                rd_tag_s1;
	logic [AW-1:0]       rd_idx_s1;
	logic [ID_W-1:0]     id_rd_s1;
	logic [ID_W-1:0]     id_mem [DEPTH];
	logic                done_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] handle_q;

	logic                accept;
	logic                issue;
	logic                cmp_eq, cmp_lt;
	logic                hit, last;
	logic [CNT_W-1:0]    pool_n;
	stk_ctrl_t           stk_ctrl;
	stk_stat_t           stk_stat;

	// controls from the output block
	logic                id_rd_en;
	logic [AW-1:0]       id_rd_addr;
	logic                id_wr_en;
	logic                res_fire;
	status_t             res_status;
	logic [HANDLE_W-1:0] res_handle;
	logic                clr_used, clr_table, set_hit, set_alloc, retire;
	logic                idx_clr, oi_clr, oi_inc, key_load, rank_inc, freed_inc;

	// terms for the checks at the end
	logic                blank_word, alloc_word, alloc_ok;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cand   = valid_q & ~used_q;
	assign pool_n = (hiu_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : hiu_q;
	assign issue  = (idx_q < IW'(DEPTH));

	fha_cmp u_cmp (
		.a  (id_rd_s1),
		.b  (id_q),
		.eq (cmp_eq),
		.lt (cmp_lt)
	);

	fha_stack #(.DEPTH(DEPTH)) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (stk_ctrl),
		.stat   (stk_stat)
	);

	assign hit  = rd_tag_s1 && valid_q[rd_idx_s1] && cmp_eq;
	assign last = rd_tag_s1 && (rd_idx_s1 == AW'(DEPTH - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && kind == KIND_LOOKUP) begin
					state_d = S_LK_SCAN;
				end else if (accept && kind == KIND_END) begin
					state_d = S_EF_OUTER;
				end
			end
			S_LK_SCAN: begin
				priority if (hit) begin
					state_d = S_IDLE;
				end else if (last && stk_stat.count == '0) begin
					state_d = S_IDLE;
				end else if (last) begin
					state_d = S_LK_POP;
				end
			end
			S_LK_POP:   state_d = S_LK_ALLOC;
			S_LK_ALLOC: state_d = S_IDLE;
			S_EF_OUTER: begin
				if (oi_q == IW'(DEPTH)) begin
					state_d = S_EF_FIN;
				end else if (cand[oi_q[AW-1:0]]) begin
					state_d = S_EF_LOAD;
				end
			end
			S_EF_LOAD:  state_d = S_EF_INNER;
			S_EF_INNER: begin
				if (last) begin
					state_d = S_EF_PUSH;
				end
			end
			S_EF_PUSH:  state_d = S_EF_OUTER;
			S_EF_FIN:   state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		id_rd_en   = 1'b0;
		id_rd_addr = idx_q[AW-1:0];
		id_wr_en   = 1'b0;
		res_fire   = 1'b0;
		res_status = ST_DONE;
		res_handle = '0;
		clr_used   = 1'b0;
		clr_table  = 1'b0;
		set_hit    = 1'b0;
		set_alloc  = 1'b0;
		retire     = 1'b0;
		idx_clr    = 1'b0;
		oi_clr     = 1'b0;
		oi_inc     = 1'b0;
		key_load   = 1'b0;
		rank_inc   = 1'b0;
		freed_inc  = 1'b0;
		stk_ctrl   = '0;
		stk_ctrl.init_n  = pool_n;
		stk_ctrl.wr_pos  = HANDLE_W'(stk_stat.count + rank_q);
		stk_ctrl.wr_data = HANDLE_W'(oi_q[AW-1:0]);
		stk_ctrl.add_val = freed_q;
		unique case (state_q)
			S_IDLE: begin
				idx_clr = accept;
				oi_clr  = accept;
				if (accept && kind == KIND_BEGIN) begin
					clr_used = 1'b1;
					res_fire = 1'b1;
				end
				if (accept && kind == KIND_RESET) begin
					clr_table     = 1'b1;
					stk_ctrl.init = 1'b1;
					res_fire      = 1'b1;
				end
			end
			S_LK_SCAN: begin
				id_rd_en = issue;
				priority if (hit) begin
					set_hit    = 1'b1;
					res_fire   = 1'b1;
					res_status = ST_FOUND;
					res_handle = HANDLE_W'(rd_idx_s1);
				end else if (last && stk_stat.count == '0) begin
					res_fire   = 1'b1;
					res_status = ST_FULL;
				end else begin
					res_fire = 1'b0;
				end
			end
			S_LK_POP: begin
				stk_ctrl.rd_en = 1'b1;
			end
			S_LK_ALLOC: begin
				stk_ctrl.pop = 1'b1;
				id_wr_en     = 1'b1;
				set_alloc    = 1'b1;
				res_fire     = 1'b1;
				res_status   = ST_ALLOC;
				res_handle   = stk_stat.top;
			end
			S_EF_OUTER: begin
				id_rd_addr = oi_q[AW-1:0];
				if (oi_q != IW'(DEPTH)) begin
					id_rd_en = cand[oi_q[AW-1:0]];
					oi_inc   = !cand[oi_q[AW-1:0]];
				end
			end
			S_EF_LOAD: begin
				key_load = 1'b1;
				idx_clr  = 1'b1;
			end
			S_EF_INNER: begin
				id_rd_en = issue;
				rank_inc = rd_tag_s1 && cand[rd_idx_s1] && cmp_lt;
			end
			S_EF_PUSH: begin
				// freed entries go above the current top in ascending id order
				stk_ctrl.wr_en = 1'b1;
				freed_inc      = 1'b1;
				oi_inc         = 1'b1;
			end
			S_EF_FIN: begin
				stk_ctrl.add_en = 1'b1;
				retire          = 1'b1;
				res_fire        = 1'b1;
			end
			default: begin
				res_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			hiu_q     <= CNT_W'(MAX_POOL);
			valid_q   <= '0;
			used_q    <= '0;
			done_q    <= 1'b0;
			rd_tag_s1 <= 1'b0;
			idx_q     <= '0;
			oi_q      <= '0;
			rank_q    <= '0;
			freed_q   <= '0;
		end else begin
			state_q   <= state_d;
			done_q    <= res_fire;
			rd_tag_s1 <= id_rd_en;
			if (cfg_we) begin
				hiu_q <= cfg_wdata;
			end
			if (clr_table) begin
				valid_q <= '0;
				used_q  <= '0;
			end else if (clr_used) begin
				used_q <= '0;
			end else if (retire) begin
				valid_q <= valid_q & used_q;
			end else if (set_hit) begin
				used_q[rd_idx_s1] <= 1'b1;
			end else if (set_alloc) begin
				valid_q[stk_stat.top[AW-1:0]] <= 1'b1;
				used_q[stk_stat.top[AW-1:0]]  <= 1'b1;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (id_rd_en && state_q != S_EF_OUTER) begin
				idx_q <= idx_q + IW'(1);
			end
			if (oi_clr) begin
				oi_q    <= '0;
				freed_q <= '0;
			end else begin
				if (oi_inc) begin
					oi_q <= oi_q + IW'(1);
				end
				if (freed_inc) begin
					freed_q <= freed_q + CNT_W'(1);
				end
			end
			if (key_load) begin
				rank_q <= '0;
			end else if (rank_inc) begin
				rank_q <= rank_q + CNT_W'(1);
			end
		end
	end

	// id table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (id_wr_en) begin
			id_mem[stk_stat.top[AW-1:0]] <= id_q;
		end
		if (id_rd_en) begin
			id_rd_s1 <= id_mem[id_rd_addr];
		end
		rd_idx_s1 <= id_rd_addr;
		if (accept) begin
			id_q <= id;
		end else if (key_load) begin
			id_q <= id_rd_s1;
		end
		if (res_fire) begin
			status_q <= res_status;
			handle_q <= res_handle;
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign handle = handle_q;

	assign blank_word = done && (status == ST_FULL || status == ST_DONE);
	assign alloc_word = done && status == ST_ALLOC;
	assign alloc_ok   = valid_q[handle[AW-1:0]] && used_q[handle[AW-1:0]];

	`FHA_ASSERT_IMP(a_fall_gives_word, $fell(busy), done, "busy dropped without a result word")
	`FHA_ASSERT_IMP(a_handle_zero, blank_word, handle == '0, "handle not zero on full or done")
	`FHA_ASSERT_IMP(a_alloc_marked, alloc_word, alloc_ok, "allocated handle not valid and used")
	`FHA_ASSERT_NEVER(a_count_range, stk_stat.count > CNT_W'(DEPTH), "free count above pool size")

endmodule

`default_nettype wire
